[rtl/core/l2bf_pkg.sv]
// l2bf_pkg: shared types and codes for the layer-2 bridge flood replicator.
// Holds item structs, table write/read structs and the job record of the queue.
// No dependencies.
package l2bf_pkg;

    localparam logic [1:0] KIND_PACKET   = 2'd0;
    localparam logic [1:0] KIND_WR_IFACE = 2'd1;
    localparam logic [1:0] KIND_WR_SLOT  = 2'd2;
    localparam logic [1:0] KIND_WR_COUNT = 2'd3;

    localparam logic [1:0] IFACE_ABSENT = 2'd0;
    localparam logic [1:0] IFACE_PORT   = 2'd1;
    localparam logic [1:0] IFACE_BRIDGE = 2'd2;
    localparam logic [1:0] IFACE_VXLAN  = 2'd3;

    localparam logic [1:0] EDGE_OUTPUT = 2'd0;
    localparam logic [1:0] EDGE_INPUT  = 2'd1;
    localparam logic [1:0] EDGE_VXLAN  = 2'd2;
    localparam logic [1:0] EDGE_DROP   = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] packet_tag;
        logic [5:0]  iface_id;
        logic [5:0]  domain;
        logic        up_flag;
        logic [1:0]  iface_kind;
        logic [3:0]  slot;
        logic [5:0]  member_id;
        logic [4:0]  member_total;
    } t_in_item;

    typedef struct packed {
        logic [15:0] copy_tag;
        logic [5:0]  dest_iface;
        logic [1:0]  edge_res;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic        ifc_we;
        logic        slot_we;
        logic        cnt_we;
        logic [5:0]  id;
        logic [5:0]  domain;
        logic        up_flag;
        logic [1:0]  iface_kind;
        logic [3:0]  slot;
        logic [5:0]  member_id;
        logic [4:0]  member_total;
    } t_tbl_wr;

    typedef struct packed {
        logic [5:0]  domain;
        logic        up_flag;
        logic [1:0]  iface_kind;
    } t_ifc_rd;

    typedef struct packed {
        logic [15:0] tag;
        logic [5:0]  src;
        logic [5:0]  br;
        logic [4:0]  cnt;
        logic        br_copy;
    } t_job;

endpackage

[rtl/core/l2_bridge_flood_replicator_core.sv]
// Output: at most one directive a cycle, gaps on skipped members. The receiver cannot stall
// the results. Flow: busy while a packet is classified and handed on, longer while the
// 2-deep job queue is full; the front takes a new packet while the replicator still works
// on earlier ones. A write is held busy until every queued packet has finished.
// Reset: synchronous, active low; clears table valid bits, no clearing pass.
module l2_bridge_flood_replicator_core #(
    parameter int MAX_IFACES  = 64,
    parameter int MAX_MEMBERS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  l2bf_pkg::t_in_item    i_item,
    output logic                  o_strobe,
    output l2bf_pkg::t_out_item   o_result
);

    l2bf_pkg::t_tbl_wr  w_wr;
    logic [5:0]         w_a_id;
    l2bf_pkg::t_ifc_rd  w_a;
    logic [4:0]         w_a_cnt;
    logic [5:0]         w_b_id;
    logic [1:0]         w_b_kind;
    logic               w_b_up;
    logic               w_m_re;
    logic [5:0]         w_m_br;
    logic [4:0]         w_m_slot;
    logic [5:0]         w_m_id;
    logic               w_push;
    l2bf_pkg::t_job     w_job_in;
    logic               w_full;
    logic               w_pop;
    l2bf_pkg::t_job     w_job_out;
    logic               w_empty;
    logic               w_back_idle;
    logic               w_drained;

    assign w_drained = w_empty && w_back_idle;

    l2bf_tables #(
        .MAX_IFACES  (MAX_IFACES),
        .MAX_MEMBERS (MAX_MEMBERS)
    ) u_tables (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (w_wr),
        .i_a_id   (w_a_id),
        .o_a      (w_a),
        .o_a_cnt  (w_a_cnt),
        .i_b_id   (w_b_id),
        .o_b_kind (w_b_kind),
        .o_b_up   (w_b_up),
        .i_m_re   (w_m_re),
        .i_m_br   (w_m_br),
        .i_m_slot (w_m_slot),
        .o_m_id   (w_m_id)
    );

    l2bf_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .o_busy    (busy),
        .i_item    (i_item),
        .i_drained (w_drained),
        .o_wr      (w_wr),
        .o_a_id    (w_a_id),
        .i_a       (w_a),
        .i_a_cnt   (w_a_cnt),
        .o_push    (w_push),
        .o_job     (w_job_in),
        .i_q_full  (w_full)
    );

    l2bf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_job   (w_job_out),
        .o_empty (w_empty)
    );

    l2bf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_job     (w_job_out),
        .i_q_empty (w_empty),
        .o_pop     (w_pop),
        .o_idle    (w_back_idle),
        .o_m_re    (w_m_re),
        .o_m_br    (w_m_br),
        .o_m_slot  (w_m_slot),
        .i_m_id    (w_m_id),
        .o_b_id    (w_b_id),
        .i_b_kind  (w_b_kind),
        .i_b_up    (w_b_up),
        .o_strobe  (o_strobe),
        .o_result  (o_result)
    );

endmodule

[rtl/core/l2bf_tables.sv]
// l2bf_tables: interface table, member counts and member lists.
// Two interface read ports, one member list read port, one write port.
// Depends on l2bf_pkg.
module l2bf_tables #(
    parameter int MAX_IFACES  = 64,
    parameter int MAX_MEMBERS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  l2bf_pkg::t_tbl_wr     i_wr,
    input  logic [5:0]            i_a_id,
    output l2bf_pkg::t_ifc_rd     o_a,
    output logic [4:0]            o_a_cnt,
    input  logic [5:0]            i_b_id,
    output logic [1:0]            o_b_kind,
    output logic                  o_b_up,
    input  logic                  i_m_re,
    input  logic [5:0]            i_m_br,
    input  logic [4:0]            i_m_slot,
    output logic [5:0]            o_m_id
);

    localparam int IFD   = (MAX_IFACES < 64) ? MAX_IFACES : 64;
    localparam int IW    = $clog2(IFD);
    localparam int DEPTH = IFD * MAX_MEMBERS;
    localparam int AW    = $clog2(DEPTH);

    logic [5:0]     r_dom  [IFD];
    logic           r_up   [IFD];
    logic [1:0]     r_kind [IFD];
    logic [4:0]     r_cnt  [IFD];
    logic [5:0]     r_mbr  [DEPTH];
    logic [IFD-1:0] r_ivld;
    logic [IFD-1:0] r_cvld;

    logic [5:0]     r_a_dom;
    logic           r_a_up;
    logic [1:0]     r_a_kind;
    logic           r_a_v;
    logic [4:0]     r_a_cnt;
    logic           r_a_cv;
    logic           r_b_up;
    logic [1:0]     r_b_kind;
    logic           r_b_v;
    logic [5:0]     r_mdata;

    logic           w_wr_ok;
    logic           w_slot_ok;
    logic [IW-1:0]  w_wr_idx;
    logic [IW-1:0]  w_a_idx;
    logic [IW-1:0]  w_b_idx;
    logic [AW-1:0]  w_waddr;
    logic [AW-1:0]  w_raddr;
    logic [4:0]     w_total;

    always_comb begin
        w_wr_ok   = 32'(i_wr.id) < IFD;
        w_slot_ok = 32'(i_wr.slot) < MAX_MEMBERS;
        w_wr_idx  = i_wr.id[IW-1:0];
        w_a_idx   = i_a_id[IW-1:0];
        w_b_idx   = i_b_id[IW-1:0];
        w_waddr   = AW'(w_wr_idx) * AW'(MAX_MEMBERS) + AW'(i_wr.slot);
        w_raddr   = AW'(i_m_br[IW-1:0]) * AW'(MAX_MEMBERS) + AW'(i_m_slot);
        w_total   = (32'(i_wr.member_total) > MAX_MEMBERS) ? 5'(MAX_MEMBERS)
                                                           : i_wr.member_total;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ivld <= '0;
            r_cvld <= '0;
        end else begin
            if (i_wr.ifc_we && w_wr_ok) begin
                r_ivld[w_wr_idx] <= 1'b1;
            end
            if (i_wr.cnt_we && w_wr_ok) begin
                r_cvld[w_wr_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.ifc_we && w_wr_ok) begin
            r_dom[w_wr_idx]  <= i_wr.domain;
            r_up[w_wr_idx]   <= i_wr.up_flag;
            r_kind[w_wr_idx] <= i_wr.iface_kind;
        end
        if (i_wr.cnt_we && w_wr_ok) begin
            r_cnt[w_wr_idx] <= w_total;
        end
        if (i_wr.slot_we && w_wr_ok && w_slot_ok) begin
            r_mbr[w_waddr] <= i_wr.member_id;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_dom  <= r_dom[w_a_idx];
        r_a_up   <= r_up[w_a_idx];
        r_a_kind <= r_kind[w_a_idx];
        r_a_v    <= r_ivld[w_a_idx] && (32'(i_a_id) < IFD);
        r_a_cnt  <= r_cnt[w_a_idx];
        r_a_cv   <= r_cvld[w_a_idx] && (32'(i_a_id) < IFD);
        r_b_up   <= r_up[w_b_idx];
        r_b_kind <= r_kind[w_b_idx];
        r_b_v    <= r_ivld[w_b_idx] && (32'(i_b_id) < IFD);
        if (i_m_re) begin
            r_mdata <= r_mbr[w_raddr];
        end
    end

    always_comb begin
        o_a.domain     = r_a_v ? r_a_dom : 6'd0;
        o_a.up_flag    = r_a_v & r_a_up;
        o_a.iface_kind = r_a_v ? r_a_kind : l2bf_pkg::IFACE_ABSENT;
        o_a_cnt        = r_a_cv ? r_a_cnt : 5'd0;
        o_b_kind       = r_b_v ? r_b_kind : l2bf_pkg::IFACE_ABSENT;
        o_b_up         = r_b_v & r_b_up;
        o_m_id         = r_mdata;
    end

endmodule

[rtl/core/l2bf_front.sv]
// l2bf_front: accepts transactions, applies table writes, classifies packets.
// Looks up source and bridge entries and hands a job to the queue.
// Depends on l2bf_pkg.
module l2bf_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  l2bf_pkg::t_in_item    i_item,
    input  logic                  i_drained,
    output l2bf_pkg::t_tbl_wr     o_wr,
    output logic [5:0]            o_a_id,
    input  l2bf_pkg::t_ifc_rd     i_a,
    input  logic [4:0]            i_a_cnt,
    output logic                  o_push,
    output l2bf_pkg::t_job        o_job,
    input  logic                  i_q_full
);

    typedef enum logic [2:0] {
        F_IDLE,
        F_SRC,
        F_BR,
        F_PUSH,
        F_WR
    } t_fstate;

    t_fstate            r_state;
    l2bf_pkg::t_in_item r_item;
    l2bf_pkg::t_job     r_job;
    logic               r_src_ok;
    logic [5:0]         r_br;
    logic               w_elig;
    logic               w_wr_go;

    always_comb begin
        o_busy  = (r_state != F_IDLE);
        o_a_id  = (r_state == F_SRC) ? i_a.domain : i_item.iface_id;
        w_elig  = r_src_ok && (i_a.iface_kind == l2bf_pkg::IFACE_BRIDGE);
        w_wr_go = (r_state == F_WR) && i_drained;
        o_push  = (r_state == F_PUSH) && !i_q_full;
        o_job   = r_job;

        o_wr.ifc_we       = w_wr_go && (r_item.kind == l2bf_pkg::KIND_WR_IFACE);
        o_wr.slot_we      = w_wr_go && (r_item.kind == l2bf_pkg::KIND_WR_SLOT);
        o_wr.cnt_we       = w_wr_go && (r_item.kind == l2bf_pkg::KIND_WR_COUNT);
        o_wr.id           = r_item.iface_id;
        o_wr.domain       = r_item.domain;
        o_wr.up_flag      = r_item.up_flag;
        o_wr.iface_kind   = r_item.iface_kind;
        o_wr.slot         = r_item.slot;
        o_wr.member_id    = r_item.member_id;
        o_wr.member_total = r_item.member_total;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (i_start) begin
                        r_item <= i_item;
                        if (i_item.kind == l2bf_pkg::KIND_PACKET) begin
                            r_state <= F_SRC;
                        end else begin
                            r_state <= F_WR;
                        end
                    end
                end
                F_SRC: begin
                    r_src_ok <= (i_a.iface_kind != l2bf_pkg::IFACE_ABSENT);
                    r_br     <= i_a.domain;
                    r_state  <= F_BR;
                end
                F_BR: begin
                    r_job.tag     <= r_item.packet_tag;
                    r_job.src     <= r_item.iface_id;
                    r_job.br      <= r_br;
                    r_job.cnt     <= w_elig ? i_a_cnt : 5'd0;
                    r_job.br_copy <= w_elig && (r_item.iface_id != r_br) && i_a.up_flag;
                    r_state       <= F_PUSH;
                end
                F_PUSH: begin
                    if (!i_q_full) begin
                        r_state <= F_IDLE;
                    end
                end
                F_WR: begin
                    if (i_drained) begin
                        r_state <= F_IDLE;
                    end
                end
                default: begin
                    r_state <= F_IDLE;
                end
            endcase
        end
    end

endmodule

[rtl/core/l2bf_queue.sv]
// l2bf_queue: short job queue between the classifier and the replicator.
// Depends on l2bf_pkg.
module l2bf_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  l2bf_pkg::t_job  i_job,
    output logic            o_full,
    input  logic            i_pop,
    output l2bf_pkg::t_job  o_job,
    output logic            o_empty
);

    localparam int QD = 2;
    localparam int PW = $clog2(QD);
    localparam int CW = $clog2(QD + 1);

    l2bf_pkg::t_job r_mem [QD];
    logic [PW-1:0]  r_wp;
    logic [PW-1:0]  r_rp;
    logic [CW-1:0]  r_cnt;
    logic           w_do_push;
    logic           w_do_pop;

    always_comb begin
        o_full    = (r_cnt == CW'(QD));
        o_empty   = (r_cnt == '0);
        o_job     = r_mem[r_rp];
        w_do_push = i_push && !o_full;
        w_do_pop  = i_pop && !o_empty;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_do_push) begin
                r_wp <= (r_wp == PW'(QD - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_do_pop) begin
                r_rp <= (r_rp == PW'(QD - 1)) ? '0 : r_rp + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

[rtl/core/l2bf_back.sv]
// l2bf_back: walks a bridge member list and emits at most one directive per cycle, with gaps on skipped members.
// Holds one directive back so the final one can carry the last mark.
// Depends on l2bf_pkg.
module l2bf_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  l2bf_pkg::t_job        i_job,
    input  logic                  i_q_empty,
    output logic                  o_pop,
    output logic                  o_idle,
    output logic                  o_m_re,
    output logic [5:0]            o_m_br,
    output logic [4:0]            o_m_slot,
    input  logic [5:0]            i_m_id,
    output logic [5:0]            o_b_id,
    input  logic [1:0]            i_b_kind,
    input  logic                  i_b_up,
    output logic                  o_strobe,
    output l2bf_pkg::t_out_item   o_result
);

    typedef enum logic [1:0] {
        B_IDLE,
        B_WALK,
        B_TAIL,
        B_FIN
    } t_bstate;

    t_bstate                r_state;
    l2bf_pkg::t_job         r_job;
    logic [4:0]             r_j;
    logic                   r_v1;
    logic                   r_v2;
    logic [5:0]             r_m2;
    logic                   r_pend_v;
    logic [5:0]             r_pend_dest;
    logic [1:0]             r_pend_edge;
    logic                   r_strobe;
    l2bf_pkg::t_out_item    r_result;

    logic                   w_issue;
    logic                   w_hit;
    logic                   w_new_v;
    logic [5:0]             w_new_dest;
    logic [1:0]             w_new_edge;

    always_comb begin
        w_issue    = (r_state == B_WALK) && (r_j < r_job.cnt);
        w_hit      = r_v2 && (r_m2 != r_job.src) &&
                     (i_b_kind != l2bf_pkg::IFACE_ABSENT) && i_b_up;
        w_new_v    = w_hit || ((r_state == B_TAIL) && r_job.br_copy);
        w_new_dest = w_hit ? r_m2 : r_job.br;
        if (!w_hit) begin
            w_new_edge = l2bf_pkg::EDGE_INPUT;
        end else if (i_b_kind == l2bf_pkg::IFACE_VXLAN) begin
            w_new_edge = l2bf_pkg::EDGE_VXLAN;
        end else begin
            w_new_edge = l2bf_pkg::EDGE_OUTPUT;
        end
        o_pop    = (r_state == B_IDLE) && !i_q_empty;
        o_idle   = (r_state == B_IDLE);
        o_m_re   = w_issue;
        o_m_br   = r_job.br;
        o_m_slot = r_j;
        o_b_id   = i_m_id;
        o_strobe = r_strobe;
        o_result = r_result;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_pend_v <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            r_v1     <= w_issue;
            r_v2     <= r_v1;
            r_m2     <= i_m_id;

            if (w_new_v) begin
                if (r_pend_v) begin
                    r_strobe <= 1'b1;
                    r_result <= '{copy_tag: r_job.tag, dest_iface: r_pend_dest,
                                  edge_res: r_pend_edge, last: 1'b0};
                end
                r_pend_v    <= 1'b1;
                r_pend_dest <= w_new_dest;
                r_pend_edge <= w_new_edge;
            end

            case (r_state)
                B_IDLE: begin
                    if (!i_q_empty) begin
                        r_job   <= i_job;
                        r_j     <= 5'd0;
                        r_state <= B_WALK;
                    end
                end
                B_WALK: begin
                    if (w_issue) begin
                        r_j <= r_j + 5'd1;
                    end else if (!r_v1 && !r_v2) begin
                        r_state <= B_TAIL;
                    end
                end
                B_TAIL: begin
                    r_state <= B_FIN;
                end
                B_FIN: begin
                    r_strobe <= 1'b1;
                    if (r_pend_v) begin
                        r_result <= '{copy_tag: r_job.tag, dest_iface: r_pend_dest,
                                      edge_res: r_pend_edge, last: 1'b1};
                    end else begin
                        r_result <= '{copy_tag: r_job.tag, dest_iface: r_job.src,
                                      edge_res: l2bf_pkg::EDGE_DROP, last: 1'b1};
                    end
                    r_pend_v <= 1'b0;
                    r_state  <= B_IDLE;
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end

endmodule

[rtl/core/l2bf_checker.sv]
// l2bf_checker: port-level assertions for the flood replicator top level.
// Bound to l2_bridge_flood_replicator_core; depends on l2bf_pkg.
module l2bf_checker (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  logic                  o_strobe,
    input  l2bf_pkg::t_out_item   o_result
);

    a_no_strobe_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe)
        else $error("result strobe right after reset");

    a_drop_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_result.edge_res == l2bf_pkg::EDGE_DROP)) |-> o_result.last)
        else $error("drop directive without last mark");

    a_bridge_copy_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_result.edge_res == l2bf_pkg::EDGE_INPUT)) |-> o_result.last)
        else $error("bridge input copy not the final directive");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("not busy after an accepted transaction");

endmodule

bind l2_bridge_flood_replicator_core l2bf_checker u_l2bf_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_result (o_result)
);
